// ===== sv/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lkvc_op_t;

  localparam int DATA_W      = 32;  // result data field
  localparam int COUNT_W     = 4;   // entries_in_use field
  localparam int CAP_W       = 4;   // capacity register
  localparam int OUT_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef struct packed {
    logic               found;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } lkvc_result_t;

endpackage

// ===== sv/lkvc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_core
// Entry store, parallel key match and recency rank update for one item.
// ----------------------------------------------------------------------------
module lkvc_core import lkvc_pkg::*; #(
  parameter int ENTRIES    = 8,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CAP_W-1:0]      cfg_wr_data,
  input  logic                  step,
  input  logic                  op,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  output lkvc_result_t          result
);

  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DEXT_W  = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;
  localparam int CEXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [CAP_W-1:0]      capacity_r;
  logic [ENTRIES-1:0]    valid_r;
  logic [CNT_W-1:0]      count_r;
  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] value_r [ENTRIES];
  logic [RANK_W-1:0]     rank_r  [ENTRIES];

  logic [ENTRIES-1:0]    hit_vec, hit_sel, free_sel, lru_vec, lru_sel, sel;
  logic                  any_hit, is_put, has_room, upd, grow, insert;
  logic [RANK_W-1:0]     hit_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic [CNT_W-1:0]      count_m1, thr, count_nxt;
  logic [CMP_W-1:0]      eff_cap;
  logic [DEXT_W-1:0]     data_ext;
  logic [CEXT_W-1:0]     count_ext;

  assign is_put   = (op == OP_PUT);
  assign count_m1 = count_r - CNT_W'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == key);
      // ranks of valid entries are a permutation of 0..count-1
      lru_vec[i] = valid_r[i] && (CNT_W'(rank_r[i]) == count_m1);
    end
  end

  // lowest set bit
  assign hit_sel  = hit_vec & (~hit_vec + ENTRIES'(1));
  assign free_sel = ~valid_r & (valid_r + ENTRIES'(1));
  assign lru_sel  = lru_vec & (~lru_vec + ENTRIES'(1));
  assign any_hit  = |hit_vec;

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_sel[i]) begin
        hit_rank  = hit_rank | rank_r[i];
        hit_value = hit_value | value_r[i];
      end
    end
  end

  // capacity zero acts as one, above ENTRIES saturates
  always_comb begin
    if (capacity_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity_r) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity_r);
    end
  end
  assign has_room = CMP_W'(count_r) < eff_cap;

  // entries of lower rank than thr age by one, the selected entry goes to rank 0
  always_comb begin
    upd    = 1'b0;
    grow   = 1'b0;
    insert = 1'b0;
    sel    = '0;
    thr    = '0;
    if (any_hit) begin
      upd = 1'b1;
      sel = hit_sel;
      thr = CNT_W'(hit_rank);
    end else if (is_put) begin
      upd    = 1'b1;
      insert = 1'b1;
      if (has_room) begin
        grow = 1'b1;
        sel  = free_sel;
        thr  = count_r;
      end else begin
        sel = lru_sel;
        thr = count_m1;
      end
    end
  end

  assign count_nxt = count_r + CNT_W'(grow);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      valid_r    <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      if (step) begin
        if (insert) begin
          valid_r <= valid_r | sel;
        end
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (upd) begin
          if (sel[i]) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (CNT_W'(rank_r[i]) < thr)) begin
            rank_r[i] <= rank_r[i] + RANK_W'(1);
          end
        end
        if (sel[i] && is_put) begin
          value_r[i] <= value;
        end
        if (sel[i] && insert) begin
          key_r[i] <= key;
        end
      end
    end
  end

  assign data_ext  = any_hit ? DEXT_W'(hit_value) : '0;
  assign count_ext = CEXT_W'(count_nxt);

  always_comb begin
    result.found = any_hit;
    result.data  = data_ext[DATA_W-1:0];
    result.count = count_ext[COUNT_W-1:0];
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count out of step with valid bits");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("key present in more than one entry");

  a_get_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !is_put) |=> $stable(valid_r) && $stable(count_r))
    else $error("get changed the set of valid entries");

  a_put_leaves_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_put) |=> (count_r != '0))
    else $error("store empty after a put");

  a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (step && insert && !has_room) |-> $onehot(lru_vec))
    else $error("no unique least recent entry on eviction");

endmodule

// ===== sv/lru_key_value_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with LRU replacement, stream ports.
// ----------------------------------------------------------------------------
// Path: the item is taken into the input register, then key match and rank update
//   write the result register; a stalled output holds the item in the input register.
// Throughput: one item per cycle while the output is not stalled, set by the parallel key
//   compare and rank update against the entry registers.
// Reset: synchronous, active low; clears valid bits and entry count, capacity
//   returns to 8. Keys, values and ranks are not cleared.
module lru_key_value_cache_top import lkvc_pkg::*; #(
  parameter int ENTRIES    = 8,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data,     // capacity_in_use
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,  // key, value, zero pad
  input  logic [0:0]             in_tuser,        // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,       // data, entries_in_use, zero pad
  output logic [0:0]             out_tuser        // found
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_op_r;
  logic [KEY_BITS-1:0]   s1_key_r;
  logic [VALUE_BITS-1:0] s1_value_r;
  logic                  out_valid_r, out_valid_nxt;
  lkvc_result_t          out_res_r, res;
  logic                  out_free, step;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r    <= in_tuser[0];
      s1_key_r   <= in_tdata[KEY_BITS-1:0];
      s1_value_r <= in_tdata[KEY_BITS +: VALUE_BITS];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  lkvc_core #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .op          (s1_op_r),
    .key         (s1_key_r),
    .value       (s1_value_r),
    .result      (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.found;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.count, out_res_r.data});

endmodule

// ===== tb/sv/tb_lru_key_value_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Stream-level check of the LRU key/value cache. A short table of directed
// items and capacity writes comes first. Then several phases of random
// get/put traffic over small key pools, each with its own capacity and its
// own sender and receiver idling. Each reply is compared with the table's
// expected reply or with a local model of the entry store and its recency order.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
  import lkvc_pkg::*;

  localparam int ENTRIES         = 8;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int IN_W            = ((KEY_W + VAL_W + 7) / 8) * 8;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 123;
  localparam int POOL_SIZE       = 12;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int RING_AW         = 4;
  localparam int RING_DEPTH      = 1 << RING_AW;
  localparam int DIR_AW          = 5;
  localparam int DIR_DEPTH       = 1 << DIR_AW;

  typedef struct {
    bit               is_cfg;  // capacity write; val[3:0] is the capacity
    bit               typed;   // want holds the expected reply
    lkvc_op_t         op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    lkvc_result_t     want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CAP_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata;   // key, value
  logic [0:0]             in_tuser;   // op
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // data, entries_in_use, zero pad
  logic [0:0]             out_tuser;  // found

  // Local copy of the entry store
  bit               slot_valid [ENTRIES];
  logic [KEY_W-1:0] slot_key   [ENTRIES];
  logic [VAL_W-1:0] slot_value [ENTRIES];
  int               slot_age   [ENTRIES];  // 0 = most recent
  int               slots_used;
  logic [CAP_W-1:0] capacity_reg;

  // expected replies in accept order; written by the sender, read by the checker
  lkvc_result_t reply_ring [RING_DEPTH];
  int           reply_wr = 0;
  int           reply_rd = 0;
  int           mismatches  = 0;
  int           quiet_cycles = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  bit           hold_req = 1'b0;

  dir_row_t         dir_rows [DIR_DEPTH];
  int               n_dir_rows = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int               phase_cap [NUM_PHASES] = '{8, 1, 3, 8, 15, 5, 0, 2, 7, 4};
  int               phase_tx  [NUM_PHASES] = '{0, 87, 0, 15, 0, 87, 0, 15, 0, 15};
  int               phase_rx  [NUM_PHASES] = '{0, 0, 87, 15, 0, 0, 87, 15, 0, 15};

  lru_key_value_cache_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Move slot s to the front; entries that were more recent age by one.
  function automatic void make_recent(int s);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function automatic lkvc_result_t lookup_or_store(lkvc_op_t op, logic [KEY_W-1:0] key,
                                                   logic [VAL_W-1:0] val);
    lkvc_result_t r;
    int hit;
    int slot;
    int cap;
    r     = '0;
    hit   = -1;
    slot  = -1;
    cap   = int'(capacity_reg);
    if (cap < 1) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
    end
    if (hit >= 0) begin
      r.found = 1'b1;
      r.data  = slot_value[hit];
      make_recent(hit);
      if (op == OP_PUT) slot_value[hit] = val;
    end else if (op == OP_PUT) begin
      if (slots_used < cap) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !slot_valid[i]) slot = i;
        end
      end
      if (slot < 0) begin
        // full (or capacity lowered under the fill): reuse the oldest slot
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && (slot < 0 || slot_age[i] > slot_age[slot])) slot = i;
        end
        make_recent(slot);
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) slot_age[i]++;
        end
        slot_valid[slot] = 1'b1;
        slot_age[slot]   = 0;
        slots_used++;
      end
      slot_key[slot]   = key;
      slot_value[slot] = val;
    end
    r.count = COUNT_W'(slots_used);
    return r;
  endfunction

  function automatic dir_row_t mk_item(lkvc_op_t op, logic [KEY_W-1:0] key,
                                       logic [VAL_W-1:0] val);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.typed  = 1'b0;
    r.op     = op;
    r.key    = key;
    r.val    = val;
    r.want   = '0;
    return r;
  endfunction

  function automatic dir_row_t mk_typed(lkvc_op_t op, logic [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] val, bit f,
                                        logic [DATA_W-1:0] d, int c);
    dir_row_t r;
    r            = mk_item(op, key, val);
    r.typed      = 1'b1;
    r.want.found = f;
    r.want.data  = d;
    r.want.count = COUNT_W'(c);
    return r;
  endfunction

  function automatic dir_row_t mk_cap(int c);
    dir_row_t r;
    r        = mk_item(OP_GET, '0, VAL_W'(c));
    r.is_cfg = 1'b1;
    return r;
  endfunction

  function automatic void add_row(dir_row_t r);
    dir_rows[n_dir_rows[DIR_AW-1:0]] = r;
    n_dir_rows++;
  endfunction

  // Called right after a rising edge; returns at the edge the item was taken
  // or after the random gap that follows it.
  task automatic offer_item(lkvc_op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                            bit typed, lkvc_result_t want);
    lkvc_result_t model;
    in_tvalid <= 1'b1;
    in_tdata  <= {val, key};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    model = lookup_or_store(op, key, val);
    reply_ring[reply_wr[RING_AW-1:0]] = typed ? want : model;
    reply_wr++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (reply_wr != reply_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    capacity_reg = c;
  endtask

  initial begin : reply_sink
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long back-pressure so the block fills and stalls its input
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : reply_check
    lkvc_result_t want;
    lkvc_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.found = out_tuser[0];
      got.data  = out_tdata[DATA_W-1:0];
      got.count = out_tdata[DATA_W +: COUNT_W];
      if (reply_wr == reply_rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: found=%0d data=%h count=%0d",
                   got.found, got.data, got.count);
      end else begin
        want = reply_ring[reply_rd[RING_AW-1:0]];
        reply_rd++;
        if (got.found !== want.found || got.data !== want.data ||
            got.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%h/%0d got %0d/%h/%0d",
                     want.found, want.data, want.count, got.found, got.data, got.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    lkvc_op_t         op;
    logic [KEY_W-1:0] key;
    lkvc_result_t     none;
    none        = '0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
    slots_used   = 0;
    capacity_reg = CAP_RESET;

    // empty store, extremes of key and value, put update, ignored get value
    add_row(mk_typed(OP_GET, 32'h0, 32'h0, 1'b0, 32'h0, 0));
    add_row(mk_typed(OP_PUT, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1));
    add_row(mk_typed(OP_PUT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 2));
    add_row(mk_typed(OP_GET, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF, 2));
    add_row(mk_typed(OP_PUT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, 32'h0, 2));
    add_row(mk_typed(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hA5A5_A5A5, 2));
    // fill to eight, then evict the oldest
    for (int k = 1; k <= 6; k++)
      add_row(mk_item(OP_PUT, (k[0] ? 32'h5555_5555 : 32'hAAAA_AAAA) ^ k,
                      32'h1000_0000 * k));
    add_row(mk_item(OP_PUT, 32'h0000_0007, 32'h7777_7777));
    add_row(mk_item(OP_GET, 32'h0, 32'h0));
    // capacity lowered under the fill: count must hold at eight
    add_row(mk_cap(2));
    add_row(mk_item(OP_PUT, 32'h0000_0100, 32'hDEAD_BEEF));
    add_row(mk_item(OP_GET, 32'h0000_0007, 32'h0));
    // zero capacity behaves as one
    add_row(mk_cap(0));
    add_row(mk_item(OP_PUT, 32'h0000_0200, 32'h0BAD_F00D));
    add_row(mk_item(OP_GET, 32'h0000_0200, 32'h0));
    // above the entry count saturates
    add_row(mk_cap(15));
    add_row(mk_item(OP_PUT, 32'h0000_0300, 32'h3333_3333));
    add_row(mk_item(OP_PUT, 32'h8000_0000, 32'h8000_0001));
    add_row(mk_item(OP_GET, 32'h8000_0000, 32'h0));
    add_row(mk_cap(1));
    add_row(mk_item(OP_PUT, 32'h0000_0500, 32'h5050_5050));
    add_row(mk_item(OP_GET, 32'h0000_0300, 32'h0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < n_dir_rows; i++) begin
      if (dir_rows[i].is_cfg)
        set_capacity(dir_rows[i].val[CAP_W-1:0]);
      else
        offer_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val,
                   dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      foreach (key_pool[i]) key_pool[i] = $urandom;
      set_capacity(CAP_W'(phase_cap[p]));
      tx_idle_pct  = phase_tx[p];
      rx_stall_pct = phase_rx[p];
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op  = ($urandom_range(1) == 1) ? OP_PUT : OP_GET;
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
        offer_item(op, key, $urandom, 1'b0, none);
      end
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    drain_replies();
    if (mismatches == 0 && reply_wr == reply_rd) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
